// ----- rtl/dwarf_encoded_value_decoder_top_defines.svh -----
// Assertion macros shared by the decoder's top level.
`ifndef DWARF_ENCODED_VALUE_DECODER_TOP_DEFINES_SVH
`define DWARF_ENCODED_VALUE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DWEV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DWEV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/dwev_pkg.sv -----
package dwev_pkg;

  // Input transaction: one byte of the encoded stream.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [7:0]  value_encoding;
    logic [63:0] byte_address;
  } item_t;

  // Result transaction: one decoded value.
  typedef struct packed {
    logic [63:0] decoded_value;
    logic [1:0]  status;
    logic        byte_consumed;
  } result_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_UNKNOWN_FORMAT  = 2'd1,
    ST_BAD_APPLICATION = 2'd2,
    ST_INDIRECT        = 2'd3
  } status_t;

  // Encoding byte that means the value is omitted.
  localparam logic [7:0] ENC_OMIT = 8'hFF;

  // Format codes (low nibble of the encoding).
  localparam logic [3:0] FMT_ABS8 = 4'h0;
  localparam logic [3:0] FMT_ULEB = 4'h1;
  localparam logic [3:0] FMT_U2   = 4'h2;
  localparam logic [3:0] FMT_U4   = 4'h3;
  localparam logic [3:0] FMT_U8   = 4'h4;
  localparam logic [3:0] FMT_SLEB = 4'h9;
  localparam logic [3:0] FMT_S2   = 4'hA;
  localparam logic [3:0] FMT_S4   = 4'hB;
  localparam logic [3:0] FMT_S8   = 4'hC;

  // Application codes (bits 6:4 of the encoding).
  localparam logic [2:0] APP_ABS   = 3'd0;
  localparam logic [2:0] APP_PCREL = 3'd1;

  localparam int ACC_W = 64;
  localparam int POS_W = 7;

  // Decoded properties of a format nibble.
  typedef struct packed {
    logic       known;
    logic       leb;
    logic [3:0] nbytes;
  } fmt_info_t;

  // Outcome of one decode step, handed to the result register.
  typedef struct packed {
    logic    emit;
    result_t result;
  } step_t;

  function automatic fmt_info_t fmt_info(input logic [3:0] fmt);
    fmt_info_t fi;
    fi = '0;
    case (fmt) inside
      FMT_ABS8, FMT_U8, FMT_S8: begin
        fi.known  = 1'b1;
        fi.nbytes = 4'd8;
      end
      FMT_U2, FMT_S2: begin
        fi.known  = 1'b1;
        fi.nbytes = 4'd2;
      end
      FMT_U4, FMT_S4: begin
        fi.known  = 1'b1;
        fi.nbytes = 4'd4;
      end
      FMT_ULEB, FMT_SLEB: begin
        fi.known = 1'b1;
        fi.leb   = 1'b1;
      end
      default: fi = '0;
    endcase
    return fi;
  endfunction

endpackage

// ----- rtl/dwarf_encoded_value_decoder_top.sv -----
// Decoder for exception-header encoded values, one stream byte per transaction.
// Input channel (item_valid / item_stall / item): each transaction carries a
// byte, a first-byte flag, and on a first byte the encoding and its address.
// Output channel (result_valid / result_stall / result): the decoded value,
// a status code and a flag that tells whether the byte was used.
// A result appears on the byte that completes a value, or at once on a first
// byte whose encoding is omit, unknown or an unsupported application mode.
// The last byte of a value is loaded into the input register when accepted,
// and its result is then loaded from there into the result register.
// Throughput: one byte per cycle; the decode of a byte is a single pass of
// shift, sign fill and address add between those two registers.
// When the receiver stalls, the result register holds its transaction, the
// byte in the input register waits, and item_stall rises once both are full.
// Reset (rst, synchronous) empties both registers and leaves the decoder idle,
// so bytes without a first-byte flag are dropped until a new value begins.
`include "dwarf_encoded_value_decoder_top_defines.svh"

module dwarf_encoded_value_decoder_top import dwev_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic  held_valid;
  item_t held_item;
  logic  out_ready;
  logic  take;
  step_t step;
  logic  busy;
  logic  out_blocked;
  logic  unused_byte;
  logic  zero_ok;
  logic  rejected;

  // A held byte is processed when the result register has room.
  assign take = held_valid && out_ready;

  dwev_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .item_stall (item_stall),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  dwev_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (held_item),
    .step (step),
    .busy (busy)
  );

  dwev_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (take && step.emit),
    .next_result  (step.result),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .ready        (out_ready)
  );

  // Conditions watched by the checks below.
  assign out_blocked = result_valid && result_stall;
  assign unused_byte = result_valid && !result.byte_consumed;
  assign zero_ok     = (result.decoded_value == 64'd0) && (result.status == ST_OK);
  assign rejected    = take && held_item.first_byte && step.emit &&
                       (step.result.status inside {ST_UNKNOWN_FORMAT, ST_BAD_APPLICATION});

  // Both stages full with the receiver stalled must hold off the sender.
  `DWEV_ASSERT_IMPLY(a_backpressure, clk, rst, held_valid && out_blocked, item_stall)
  // Only an omitted value leaves its byte unused, and it always reads as zero.
  `DWEV_ASSERT_IMPLY(a_omit_zero, clk, rst, unused_byte, zero_ok)
  // A first byte that is rejected leaves the decoder idle.
  `DWEV_ASSERT_NEXT(a_reject_idle, clk, rst, rejected, !busy)

endmodule

// ----- rtl/dwev_in_reg.sv -----
module dwev_in_reg import dwev_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  item_t item,
  input  logic  take,
  output logic  item_stall,
  output logic  held_valid,
  output item_t held_item
);

  // The register can take a new transaction when empty or when its
  // current one moves on in this cycle.
  assign item_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_item <= item;
    end
  end

endmodule

// ----- rtl/dwev_decode.sv -----
module dwev_decode import dwev_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  item_t item,
  output step_t step,
  output logic  busy
);

  logic [ACC_W-1:0] accumulator;
  logic [POS_W-1:0] bit_position;
  logic [7:0]       held_encoding;
  logic [63:0]      base_address;
  logic [3:0]       bytes_left;

  logic             omit;
  logic             app_ok;
  logic             start;
  logic             eff_busy;
  fmt_info_t        new_fi;
  fmt_info_t        cur_fi;
  logic [ACC_W-1:0] cur_acc;
  logic [POS_W-1:0] cur_pos;
  logic [7:0]       cur_enc;
  logic [63:0]      cur_base;
  logic [3:0]       cur_left;
  logic [ACC_W-1:0] byte_bits;
  logic             room;
  logic [ACC_W-1:0] acc_shift;
  logic [POS_W-1:0] pos_shift;
  logic [3:0]       left_dec;
  logic             done;
  logic             sign;
  logic [ACC_W-1:0] acc_fill;
  logic [63:0]      value;

  // Classify the encoding that comes with a first byte.
  always_comb begin
    new_fi = fmt_info(item.value_encoding[3:0]);
    omit   = item.first_byte && (item.value_encoding == ENC_OMIT);
    app_ok = (item.value_encoding[6:4] == APP_ABS) ||
             (item.value_encoding[6:4] == APP_PCREL);
    start  = item.first_byte && !omit && new_fi.known && app_ok;
    eff_busy = start || (!item.first_byte && busy);
  end

  // Working state: a fresh value starts from zero at this byte.
  always_comb begin
    cur_acc  = start ? '0 : accumulator;
    cur_pos  = start ? '0 : bit_position;
    cur_enc  = start ? item.value_encoding : held_encoding;
    cur_base = start ? item.byte_address : base_address;
    cur_left = start ? new_fi.nbytes : bytes_left;
    cur_fi   = fmt_info(cur_enc[3:0]);
  end

  // Shift the byte in, then apply sign fill once the value is complete.
  always_comb begin
    byte_bits = cur_fi.leb ? {{(ACC_W-7){1'b0}}, item.data_byte[6:0]}
                           : {{(ACC_W-8){1'b0}}, item.data_byte};
    room      = !cur_pos[POS_W-1];
    acc_shift = room ? (cur_acc | (byte_bits << cur_pos[POS_W-2:0])) : cur_acc;
    pos_shift = room ? (cur_pos + (cur_fi.leb ? POS_W'(7) : POS_W'(8))) : cur_pos;
    left_dec  = cur_left - 4'd1;
    done      = cur_fi.leb ? !item.data_byte[7] : (left_dec == 4'd0);
    // For fixed formats the top bit of the last byte is the sign bit.
    sign      = cur_enc[3] && !pos_shift[POS_W-1] &&
                (cur_fi.leb ? item.data_byte[6] : item.data_byte[7]);
    acc_fill  = sign ? (acc_shift | ({ACC_W{1'b1}} << pos_shift[POS_W-2:0]))
                     : acc_shift;
    value     = acc_fill + ((cur_enc[6:4] == APP_PCREL) ? cur_base : 64'd0);
  end

  // Result of this byte, if it completes or rejects a value.
  always_comb begin
    step = '0;
    if (omit) begin
      step.emit                 = 1'b1;
      step.result.status        = ST_OK;
      step.result.byte_consumed = 1'b0;
    end else if (item.first_byte && !new_fi.known) begin
      step.emit                 = 1'b1;
      step.result.status        = ST_UNKNOWN_FORMAT;
      step.result.byte_consumed = 1'b1;
    end else if (item.first_byte && !app_ok) begin
      step.emit                 = 1'b1;
      step.result.status        = ST_BAD_APPLICATION;
      step.result.byte_consumed = 1'b1;
    end else if (eff_busy && done) begin
      step.emit                 = 1'b1;
      step.result.decoded_value = value;
      step.result.status        = cur_enc[7] ? ST_INDIRECT : ST_OK;
      step.result.byte_consumed = 1'b1;
    end
  end

  // Decoder state advances once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      accumulator   <= '0;
      bit_position  <= '0;
      held_encoding <= '0;
      base_address  <= '0;
      bytes_left    <= '0;
    end else if (take) begin
      if (item.first_byte && !start) begin
        busy <= 1'b0;
      end else if (eff_busy) begin
        busy          <= !done;
        accumulator   <= acc_shift;
        bit_position  <= pos_shift;
        held_encoding <= cur_enc;
        base_address  <= cur_base;
        bytes_left    <= cur_fi.leb ? cur_left : left_dec;
      end
    end
  end

endmodule

// ----- rtl/dwev_out_reg.sv -----
module dwev_out_reg import dwev_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t next_result,
  input  logic    result_stall,
  output logic    result_valid,
  output result_t result,
  output logic    ready
);

  // Free when empty or when the held transaction leaves this cycle.
  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      result <= next_result;
    end
  end

endmodule

// ----- bench/dwarf_encoded_value_decoder_top_tb.sv -----
`timescale 1ns / 1ps

module dwarf_encoded_value_decoder_top_tb;
  import dwev_pkg::*;

  // Codes the package leaves out: an undefined format and a bad application.
  localparam logic [3:0] FMT_UNKNOWN = 4'h5;
  localparam logic [2:0] APP_BAD = 3'd5;
  localparam logic IND_ON = 1'b1;
  localparam logic IND_OFF = 1'b0;
  localparam int RANDOM_BYTES = 400;
  localparam int PRESSURE_AFTER = 40;
  localparam int PRESSURE_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  // Bytes still to be offered, and decoded values still to arrive.
  item_t byte_stream[$];
  result_t awaited_values[$];

  // Decoder state as the bench tracks it.
  logic [63:0] dec_acc;
  logic [6:0] dec_pos;
  logic dec_busy;
  logic [7:0] dec_enc;
  logic [63:0] dec_base;
  logic [3:0] dec_left;

  result_t predicted;
  result_t awaited;
  int fail_count = 0;
  int values_seen = 0;
  int idle_cycles = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int tx_roll;
  int rx_hold = 0;
  int rx_calm = 0;
  int rx_roll;
  bit pressure_done = 1'b0;

  logic [3:0] fmt_list[9] = '{FMT_ABS8, FMT_ULEB, FMT_U2, FMT_U4, FMT_U8,
                              FMT_SLEB, FMT_S2, FMT_S4, FMT_S8};

  dwarf_encoded_value_decoder_top uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bytes in a fixed-size format, 0 for LEB128, -1 for an undefined format.
  function automatic int byte_count(input logic [3:0] fmt);
    case (fmt)
      FMT_ABS8, FMT_U8, FMT_S8: return 8;
      FMT_U2, FMT_S2: return 2;
      FMT_U4, FMT_S4: return 4;
      FMT_ULEB, FMT_SLEB: return 0;
      default: return -1;
    endcase
  endfunction

  // Advances the decoder state by one byte; returns 1 when a value comes out.
  function automatic bit decode_byte(input item_t it, output result_t r);
    logic [3:0] fmt;
    logic [7:0] b;
    int n;
    r = '0;
    b = it.data_byte;
    if (it.first_byte) begin
      dec_busy = 1'b0;
      if (it.value_encoding == ENC_OMIT) begin
        r.status = ST_OK;
        return 1'b1;
      end
      n = byte_count(it.value_encoding[3:0]);
      r.byte_consumed = 1'b1;
      if (n < 0) begin
        r.status = ST_UNKNOWN_FORMAT;
        return 1'b1;
      end
      if (it.value_encoding[6:4] != APP_ABS && it.value_encoding[6:4] != APP_PCREL) begin
        r.status = ST_BAD_APPLICATION;
        return 1'b1;
      end
      dec_acc = '0;
      dec_pos = '0;
      dec_enc = it.value_encoding;
      dec_base = it.byte_address;
      dec_left = n[3:0];
      dec_busy = 1'b1;
    end
    if (!dec_busy) return 1'b0;

    fmt = dec_enc[3:0];
    if (fmt == FMT_ULEB || fmt == FMT_SLEB) begin
      // Seven bits per byte; bits past 63 fall off.
      if (dec_pos < 64) begin
        dec_acc |= {57'd0, b[6:0]} << dec_pos;
        dec_pos += 7;
      end
      if (b[7]) return 1'b0;
      if (fmt == FMT_SLEB && b[6] && dec_pos < 64) dec_acc |= ~64'd0 << dec_pos;
    end else begin
      // Little-endian fixed field, sign filled for the signed formats.
      if (dec_pos < 64) begin
        dec_acc |= {56'd0, b} << dec_pos;
        dec_pos += 8;
      end
      dec_left -= 4'd1;
      if (dec_left != 0) return 1'b0;
      if (fmt[3] && dec_pos > 0 && dec_pos < 64 && dec_acc[dec_pos - 1])
        dec_acc |= ~64'd0 << dec_pos;
    end

    dec_busy = 1'b0;
    r.decoded_value = dec_acc + ((dec_enc[6:4] == APP_PCREL) ? dec_base : 64'd0);
    r.status = dec_enc[7] ? ST_INDIRECT : ST_OK;
    r.byte_consumed = 1'b1;
    return 1'b1;
  endfunction

  // Random values that hit the all-zero and all-one extremes now and then.
  function automatic logic [7:0] random_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] random_address();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic first,
                           input logic [7:0] enc, input logic [63:0] addr);
    item_t it;
    it.data_byte = b;
    it.first_byte = first;
    it.value_encoding = enc;
    it.byte_address = addr;
    byte_stream.push_back(it);
  endtask

  // Queues one value of len bytes; a broken LEB128 value never terminates.
  task automatic send_value(input logic [7:0] enc, input int len, input bit broken);
    logic [7:0] b;
    bit leb;
    leb = (byte_count(enc[3:0]) == 0);
    for (int i = 0; i < len; i++) begin
      b = random_byte();
      if (leb) b[7] = broken || (i < len - 1);
      push_byte(b, i == 0, (i == 0) ? enc : random_byte(), random_address());
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int random_items;
    int pick;
    int len;
    int n;
    logic [3:0] fmt;
    logic [2:0] app;
    logic [7:0] enc;

    // A stray byte with no value open is dropped.
    push_byte(8'hAA, 1'b0, 8'h00, '0);
    // Omit, undefined format and bad application each answer at once.
    push_byte(8'h5A, 1'b1, ENC_OMIT, '1);
    push_byte(8'h01, 1'b1, {IND_ON, APP_PCREL, FMT_UNKNOWN}, 64'h10);
    push_byte(8'h02, 1'b1, {IND_OFF, APP_BAD, FMT_S4}, 64'h20);
    // One-byte LEB128 values, the signed one negative.
    push_byte(8'h7F, 1'b1, {IND_OFF, APP_ABS, FMT_ULEB}, '0);
    push_byte(8'h40, 1'b1, {IND_OFF, APP_ABS, FMT_SLEB}, '0);
    // Largest unsigned 2-byte value.
    push_byte(8'hFF, 1'b1, {IND_OFF, APP_ABS, FMT_U2}, '0);
    push_byte(8'hFF, 1'b0, 8'h00, '0);
    // Most negative 2-byte value, pc-relative at the top address so it wraps.
    push_byte(8'h00, 1'b1, {IND_OFF, APP_PCREL, FMT_S2}, '1);
    push_byte(8'h80, 1'b0, 8'hFF, '1);
    // Indirect 4-byte value, all ones.
    push_byte(8'hFF, 1'b1, {IND_ON, APP_ABS, FMT_U4}, 64'h1234);
    for (int i = 0; i < 3; i++) push_byte(8'hFF, 1'b0, 8'h00, '0);
    // Largest positive signed 4-byte value.
    push_byte(8'hFF, 1'b1, {IND_OFF, APP_ABS, FMT_S4}, '0);
    push_byte(8'hFF, 1'b0, 8'h00, '0);
    push_byte(8'hFF, 1'b0, 8'h00, '0);
    push_byte(8'h7F, 1'b0, 8'h00, '0);
    // An 8-byte value abandoned after three bytes by a new pc-relative one.
    push_byte(8'h11, 1'b1, {IND_OFF, APP_ABS, FMT_U8}, '0);
    push_byte(8'h22, 1'b0, 8'h00, '0);
    push_byte(8'h33, 1'b0, 8'h00, '0);
    push_byte(8'h80, 1'b1, {IND_OFF, APP_PCREL, FMT_ABS8}, 64'h8000_0000_0000_0000);
    for (int i = 0; i < 7; i++) push_byte(8'hFF, 1'b0, 8'h00, '0);

    // Mostly well-formed values, with broken values and noise mixed in.
    random_items = 0;
    while (random_items < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      fmt = fmt_list[$urandom_range(0, 8)];
      app = $urandom_range(0, 1) ? APP_PCREL : APP_ABS;
      enc = {$urandom_range(0, 3) == 0 ? IND_ON : IND_OFF, app, fmt};
      n = byte_count(fmt);
      if (n == 0) len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      else len = n;
      if (pick < 78) begin
        send_value(enc, len, 1'b0);
        random_items += len;
      end else if (pick < 86) begin
        if (n > 0) len = $urandom_range(1, n - 1);
        send_value(enc, len, 1'b1);
        random_items += len;
      end else if (pick < 93) begin
        push_byte(random_byte(), 1'b1, 8'($urandom_range(0, 255)), random_address());
        random_items++;
      end else if (pick < 97) begin
        push_byte(random_byte(), 1'b1, ENC_OMIT, random_address());
        random_items++;
      end else begin
        push_byte(random_byte(), 1'b0, random_byte(), random_address());
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (byte_stream.size() != 0 || item_valid || awaited_values.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: predicts each accepted byte and offers the next after a random gap.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      tx_gap = 0;
      dec_acc = '0;
      dec_pos = '0;
      dec_busy = 1'b0;
      dec_enc = '0;
      dec_base = '0;
      dec_left = '0;
    end else begin
      if (item_valid && !item_stall) begin
        if (decode_byte(item, predicted)) awaited_values.push_back(predicted);
      end
      if (!item_valid || !item_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          item_valid <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          item <= byte_stream.pop_front();
          item_valid <= 1'b1;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_roll = $urandom_range(0, 99);
            if (tx_roll < 4) tx_calm = $urandom_range(20, 60);
            else if (tx_roll < 60) tx_gap = 0;
            else if (tx_roll < 95) tx_gap = $urandom_range(1, 3);
            else tx_gap = $urandom_range(8, 30);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and stalls the output at random.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        values_seen++;
        if (awaited_values.size() == 0) begin
          $error("unexpected result transaction, decoded_value %h", result.decoded_value);
          fail_count++;
        end else begin
          awaited = awaited_values.pop_front();
          if (result.decoded_value !== awaited.decoded_value) begin
            $error("decoded_value: expected %h, actual %h",
                   awaited.decoded_value, result.decoded_value);
            fail_count++;
          end
          if (result.status !== awaited.status) begin
            $error("status: expected %0d, actual %0d", awaited.status, result.status);
            fail_count++;
          end
          if (result.byte_consumed !== awaited.byte_consumed) begin
            $error("byte_consumed: expected %0d, actual %0d",
                   awaited.byte_consumed, result.byte_consumed);
            fail_count++;
          end
        end
      end

      // One long hold-off so the block fills up and pushes back on its input.
      if (!pressure_done && values_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        rx_hold = PRESSURE_CYCLES;
      end

      if (rx_hold > 0) begin
        rx_hold--;
        result_stall <= 1'b1;
      end else if (rx_calm > 0) begin
        rx_calm--;
        result_stall <= 1'b0;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 3) begin
          rx_calm = $urandom_range(20, 60);
          result_stall <= 1'b0;
        end else if (rx_roll < 70) begin
          result_stall <= 1'b0;
        end else if (rx_roll < 97) begin
          result_stall <= 1'b1;
        end else begin
          rx_hold = $urandom_range(8, 30);
          result_stall <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
